// ===== rtl/core/v4n_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4n_pkg
// Shared constants for the four-component vector length and normalise block.
// ----------------------------------------------------------------------------
package v4n_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 14;
  localparam int UNIT_WIDTH     = 16;
  // Quotient bits of the scaled ratio and root bits of its square root.
  localparam int QUO_WIDTH      = 2 * FRAC_BITS + 1;
  localparam int UROOT_WIDTH    = FRAC_BITS + 1;
  localparam int NUM_LANES      = 4;

  localparam logic [1:0] KIND_SQUARE = 2'd0;
  localparam logic [1:0] KIND_LENGTH = 2'd1;
  localparam logic [1:0] KIND_NORM   = 2'd2;

endpackage

// ===== rtl/core/v4n_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4n_div_cell
// One step of a restoring divider chain: yields one quotient bit a cycle.
// ----------------------------------------------------------------------------
module v4n_div_cell #(
  parameter int DW    = 33,
  parameter int QW    = 29,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic [DW:0]   rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [DW-1:0] den_i,
  output logic [DW:0]   rem_o,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] den_o
);
  import v4n_pkg::*;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic [DW:0]   rem_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] den_r;

  // The first step compares the numerator itself; later steps shift first.
  assign rem_sh  = FIRST ? rem_i : {rem_i[DW-1:0], 1'b0};
  assign ge      = (rem_sh >= {1'b0, den_i});
  assign rem_nxt = ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
  assign quo_nxt = {quo_i[QW-2:0], ge};

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_i;
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign den_o = den_r;

endmodule

// ===== rtl/core/v4n_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4n_sqrt_cell
// One step of a digit-by-digit square root chain: one root bit a cycle.
// ----------------------------------------------------------------------------
module v4n_sqrt_cell #(
  parameter int K = 15
) (
  input  logic           clk,
  input  logic [K+1:0]   rem_i,
  input  logic [K-1:0]   root_i,
  input  logic [2*K-1:0] n_i,
  output logic [K+1:0]   rem_o,
  output logic [K-1:0]   root_o,
  output logic [2*K-1:0] n_o
);
  import v4n_pkg::*;

  logic [K+1:0]   rem_sh;
  logic [K+1:0]   trial;
  logic           ge;
  logic [K+1:0]   rem_r;
  logic [K-1:0]   root_r;
  logic [2*K-1:0] n_r;

  // The partial remainder never reaches 2^K before the last step.
  assign rem_sh = {rem_i[K-1:0], n_i[2*K-1:2*K-2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    rem_r  <= ge ? (rem_sh - trial) : rem_sh;
    root_r <= {root_i[K-2:0], ge};
    n_r    <= {n_i[2*K-3:0], 2'b00};
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign n_o    = n_r;

endmodule

// ===== rtl/core/vec4_length_normalize_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_length_normalize_top
// Squared length, integer length and Q1.14 unit vector of a 4-vector.
//
// An item (kind and four signed components) is taken at each rising edge
// where start is high; busy is always low, so one item per cycle is taken.
// Each item gives one result, shown for a single cycle with out_valid high.
// Throughput is one item per cycle. Each item passes the front-end
// registers, then the chain of divider cells (one quotient bit per cell)
// followed by the chain of square root cells (one root bit per cell) in
// each of the four lanes, then the output register; the length root has
// its own shorter chain and is delayed to line up.
// The receiver cannot stall, so results leave in order with no buffering.
// Reset clears the valid bits of the pipeline; items in flight are dropped.
// A zero vector sets out_zero_length and gives zero unit components.
// ----------------------------------------------------------------------------
module vec4_length_normalize_top #(
  parameter int COMP_WIDTH = v4n_pkg::COMP_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_kind,
  input  logic signed [COMP_WIDTH-1:0]          in_comp_x,
  input  logic signed [COMP_WIDTH-1:0]          in_comp_y,
  input  logic signed [COMP_WIDTH-1:0]          in_comp_z,
  input  logic signed [COMP_WIDTH-1:0]          in_comp_w,
  output logic                                  out_valid,
  output logic [2*COMP_WIDTH:0]                 out_length_square,
  output logic [COMP_WIDTH:0]                   out_length_root,
  output logic signed [v4n_pkg::UNIT_WIDTH-1:0] out_unit_x,
  output logic signed [v4n_pkg::UNIT_WIDTH-1:0] out_unit_y,
  output logic signed [v4n_pkg::UNIT_WIDTH-1:0] out_unit_z,
  output logic signed [v4n_pkg::UNIT_WIDTH-1:0] out_unit_w,
  output logic                                  out_zero_length
);
  import v4n_pkg::*;

  localparam int W   = COMP_WIDTH;
  localparam int DW  = 2 * W + 1;
  localparam int RK  = W + 1;
  localparam int UK  = UROOT_WIDTH;
  localparam int QW  = QUO_WIDTH;
  localparam int D   = QW + UK;
  localparam int RD  = D - RK;
  localparam int NL  = NUM_LANES;

  logic [W-1:0]   comp_in [NL];
  logic [W-1:0]   mag_r   [NL];
  logic [NL-1:0]  neg0_r, neg1_r, neg2_r;
  logic [1:0]     kind0_r, kind1_r, kind2_r;
  logic           vld0_r, vld1_r, vld2_r;
  logic [2*W-1:0] sq_r    [NL];
  logic [2*W-1:0] sq2_r   [NL];
  logic [DW-1:0]  sum_r;

  logic           vld_line_r  [D];
  logic [1:0]     kind_line_r [D];
  logic [NL-1:0]  neg_line_r  [D];
  logic [DW-1:0]  sum_line_r  [D];
  logic           zero_line_r [D];
  logic [RK-1:0]  root_dly_r  [RD];

  logic [RK+1:0]   rt_rem  [RK+1];
  logic [RK-1:0]   rt_root [RK+1];
  logic [2*RK-1:0] rt_n    [RK+1];

  logic [UK-1:0]  unit_q [NL];

  assign busy = 1'b0;
  assign comp_in[0] = in_comp_x;
  assign comp_in[1] = in_comp_y;
  assign comp_in[2] = in_comp_z;
  assign comp_in[3] = in_comp_w;

  // Front end: magnitudes, squares, sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld0_r <= start;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      neg0_r[l] <= comp_in[l][W-1];
      mag_r[l]  <= comp_in[l][W-1] ? (~comp_in[l] + 1'b1) : comp_in[l];
      sq_r[l]   <= mag_r[l] * mag_r[l];
      sq2_r[l]  <= sq_r[l];
    end
    kind0_r <= in_kind;
    kind1_r <= kind0_r;
    kind2_r <= kind1_r;
    neg1_r  <= neg0_r;
    neg2_r  <= neg1_r;
    sum_r   <= ({1'b0, sq_r[0]} + {1'b0, sq_r[1]}) + ({1'b0, sq_r[2]} + {1'b0, sq_r[3]});
  end

  // Side information travels alongside the cell chains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) begin
        vld_line_r[i] <= 1'b0;
      end
    end else begin
      vld_line_r[0] <= vld2_r;
      for (int i = 1; i < D; i++) begin
        vld_line_r[i] <= vld_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_line_r[0] <= kind2_r;
    neg_line_r[0]  <= neg2_r;
    sum_line_r[0]  <= sum_r;
    zero_line_r[0] <= (sum_r == '0);
    for (int i = 1; i < D; i++) begin
      kind_line_r[i] <= kind_line_r[i-1];
      neg_line_r[i]  <= neg_line_r[i-1];
      sum_line_r[i]  <= sum_line_r[i-1];
      zero_line_r[i] <= zero_line_r[i-1];
    end
    root_dly_r[0] <= rt_root[RK];
    for (int i = 1; i < RD; i++) begin
      root_dly_r[i] <= root_dly_r[i-1];
    end
  end

  // Length root chain.
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_n[0]    = {1'b0, sum_r};

  for (genvar s = 0; s < RK; s++) begin : g_root
    v4n_sqrt_cell #(.K(RK)) u_cell (
      .clk    (clk),
      .rem_i  (rt_rem[s]),
      .root_i (rt_root[s]),
      .n_i    (rt_n[s]),
      .rem_o  (rt_rem[s+1]),
      .root_o (rt_root[s+1]),
      .n_o    (rt_n[s+1])
    );
  end

  // Per-lane divider chain then square root chain.
  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [DW:0]     dv_rem [QW+1];
    logic [QW-1:0]   dv_quo [QW+1];
    logic [DW-1:0]   dv_den [QW+1];
    logic [UK+1:0]   us_rem [UK+1];
    logic [UK-1:0]   us_root[UK+1];
    logic [2*UK-1:0] us_n   [UK+1];

    assign dv_rem[0] = {2'b00, sq2_r[l]};
    assign dv_quo[0] = '0;
    assign dv_den[0] = sum_r;

    for (genvar s = 0; s < QW; s++) begin : g_div
      v4n_div_cell #(.DW(DW), .QW(QW), .FIRST(s == 0)) u_cell (
        .clk   (clk),
        .rem_i (dv_rem[s]),
        .quo_i (dv_quo[s]),
        .den_i (dv_den[s]),
        .rem_o (dv_rem[s+1]),
        .quo_o (dv_quo[s+1]),
        .den_o (dv_den[s+1])
      );
    end

    assign us_rem[0]  = '0;
    assign us_root[0] = '0;
    assign us_n[0]    = {1'b0, dv_quo[QW]};

    for (genvar s = 0; s < UK; s++) begin : g_usq
      v4n_sqrt_cell #(.K(UK)) u_cell (
        .clk    (clk),
        .rem_i  (us_rem[s]),
        .root_i (us_root[s]),
        .n_i    (us_n[s]),
        .rem_o  (us_rem[s+1]),
        .root_o (us_root[s+1]),
        .n_o    (us_n[s+1])
      );
    end

    assign unit_q[l] = us_root[UK];
  end

  // Output register.
  logic                  out_valid_r;
  logic [DW-1:0]         sq_out_r;
  logic [RK-1:0]         root_out_r;
  logic [UNIT_WIDTH-1:0] unit_out_r [NL];
  logic                  zero_out_r;
  logic                  want_root;
  logic                  want_unit;
  logic                  sq_sat;

  assign want_root = (kind_line_r[D-1] == KIND_LENGTH) || (kind_line_r[D-1] == KIND_NORM);
  assign want_unit = (kind_line_r[D-1] == KIND_NORM) && !zero_line_r[D-1];
  // At 32-bit components the squared length of four most negative values
  // does not fit in 64 bits and is held at the 64-bit maximum.
  assign sq_sat    = (W == 32) && sum_line_r[D-1][DW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_line_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    sq_out_r   <= sq_sat ? {1'b0, {(DW-1){1'b1}}} : sum_line_r[D-1];
    zero_out_r <= zero_line_r[D-1];
    root_out_r <= want_root ? root_dly_r[RD-1] : '0;
    for (int l = 0; l < NL; l++) begin
      if (!want_unit) begin
        unit_out_r[l] <= '0;
      end else if (neg_line_r[D-1][l]) begin
        unit_out_r[l] <= UNIT_WIDTH'(-{1'b0, unit_q[l]});
      end else begin
        unit_out_r[l] <= UNIT_WIDTH'({1'b0, unit_q[l]});
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_length_square = sq_out_r;
  assign out_length_root   = root_out_r;
  assign out_unit_x        = unit_out_r[0];
  assign out_unit_y        = unit_out_r[1];
  assign out_unit_z        = unit_out_r[2];
  assign out_unit_w        = unit_out_r[3];
  assign out_zero_length   = zero_out_r;

endmodule
